/* hdl/pidc_pkg.sv */
`timescale 1ns / 1ps

package pidc_pkg;

	// sample and gain widths, all Q16.16
	localparam int DATA_W = 32;
	localparam int GAIN_W = 32;
	localparam int CAP_W  = 31;
	localparam int FRAC_W = 16;

	// exact error and its differences
	localparam int ERR_W  = DATA_W + 1;
	localparam int ESUM_W = DATA_W;
	localparam int OPND_W = ERR_W + 2;

	// product after the Q16.16 shift, and the sum of four terms
	localparam int PROD_W = GAIN_W + OPND_W - FRAC_W;
	localparam int SUM_W  = PROD_W + 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_F  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_CAP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAP = 3'd6;

	// controller modes; the spare code runs as feedforward
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_INCR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POS   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FF    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

endpackage

/* hdl/pidc_sample_if.sv */
`timescale 1ns / 1ps

interface pidc_sample_if;
	import pidc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measured;
	logic signed [DATA_W-1:0] target;

	modport source (output valid, output measured, output target, input ready);
	modport sink (input valid, input measured, input target, output ready);
endinterface

/* hdl/pidc_result_if.sv */
`timescale 1ns / 1ps

interface pidc_result_if;
	import pidc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic                     saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface

/* hdl/pid_controller_three_mode_core.sv */
`timescale 1ns / 1ps

// Three-mode PID controller on signed Q16.16 samples. Each item carries a
// measured value and a target; the error target - measured is kept exact at
// 33 bits. Mode 0 is incremental (kp*(e-e1) + clamped ki*e + kd*(e-2e1+e2)),
// mode 1 positional with the running error sum clamped to +-integral_cap,
// mode 2 (and the spare code 3) adds kf*(target - last target). Gain products
// are floored after the shift by 16; the sum is clamped to +-output_cap and
// saturated flags that clamp. One item is taken every clock unless the result
// side stalls; each item passes through an input register, an operand
// register, the multiplier register, a sum register and the output register.
// The per-item state (previous errors, error sum, last target) is updated from
// the input register as the item advances, which allows one item a clock. The
// user must write configuration only while no item is in flight; not enforced.
module pid_controller_three_mode_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data,
	pidc_sample_if.sink                            sample,
	pidc_result_if.source                          result
);
	import pidc_pkg::*;

	// configuration registers
	logic [MODE_W-1:0]        mode_q;
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q, gain_f_q;
	logic [CAP_W-1:0]         int_cap_q, out_cap_q;

	// controller state
	logic signed [ERR_W-1:0]  prev_err_q, prev2_err_q;
	logic signed [ESUM_W-1:0] err_sum_q;
	logic signed [DATA_W-1:0] prev_tgt_q;

	// pipeline
	logic                     v1_s1, v2_s2, v3_s3, v4_s4, out_valid_q;
	logic                     rdy1, rdy2, rdy3, rdy4, rdy_out, adv1;
	logic signed [DATA_W-1:0] meas_s1, tgt_s1;
	logic signed [OPND_W-1:0] op_p_s2, op_i_s2, op_d_s2, op_f_s2;
	logic                     incr_s2, incr_s3;
	logic signed [PROD_W-1:0] p_s3, i_s3, d_s3, f_s3;
	logic signed [SUM_W-1:0]  sum_s4;
	logic signed [DATA_W-1:0] drive_q;
	logic                     sat_q;

	// stage 1 logic
	logic                     mode_incr, mode_ff;
	logic signed [ERR_W-1:0]  err, tgt_diff;
	logic signed [ERR_W:0]    diff1;
	logic signed [OPND_W-1:0] diff2;
	logic signed [ERR_W:0]    esum_raw, icap_e;
	logic signed [ESUM_W-1:0] esum_next;

	// stage 3 and 4 logic
	logic signed [PROD_W-1:0] icap_p, i_term;
	logic signed [SUM_W-1:0]  sum, ocap_s;
	logic signed [DATA_W-1:0] drive_next;
	logic                     sat_next;
	logic signed [DATA_W-1:0] ocap_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_POS;
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			gain_f_q  <= '0;
			int_cap_q <= '0;
			out_cap_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MODE:    mode_q    <= cfg_data[MODE_W-1:0];
				CFG_GAIN_P:  gain_p_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:  gain_i_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:  gain_d_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_F:  gain_f_q  <= cfg_data[GAIN_W-1:0];
				CFG_INT_CAP: int_cap_q <= cfg_data[CAP_W-1:0];
				CFG_OUT_CAP: out_cap_q <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake chain: a stage loads when empty or when it empties this cycle
	assign rdy_out      = !out_valid_q || result.ready;
	assign rdy4         = !v4_s4 || rdy_out;
	assign rdy3         = !v3_s3 || rdy4;
	assign rdy2         = !v2_s2 || rdy3;
	assign rdy1         = !v1_s1 || rdy2;
	assign adv1         = v1_s1 && rdy2;
	assign sample.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v1_s1       <= sample.valid;
			if (rdy2)    v2_s2       <= v1_s1;
			if (rdy3)    v3_s3       <= v2_s2;
			if (rdy4)    v4_s4       <= v3_s3;
			if (rdy_out) out_valid_q <= v4_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (rdy1 && sample.valid) begin
			meas_s1 <= sample.measured;
			tgt_s1  <= sample.target;
		end
	end

	// error, differences and the clamped error sum
	assign mode_incr = (mode_q == MODE_INCR);
	assign mode_ff   = (mode_q == MODE_FF) || (mode_q == MODE_SPARE);
	assign err       = ERR_W'(tgt_s1) - ERR_W'(meas_s1);
	assign diff1     = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err_q);
	assign diff2     = OPND_W'(err) - (OPND_W'(prev_err_q) <<< 1) + OPND_W'(prev2_err_q);
	assign tgt_diff  = ERR_W'(tgt_s1) - ERR_W'(prev_tgt_q);
	assign esum_raw  = (ERR_W+1)'(err_sum_q) + (ERR_W+1)'(err);
	assign icap_e    = $signed((ERR_W+1)'(int_cap_q));

	always_comb begin
		if (esum_raw > icap_e) begin
			esum_next = ESUM_W'(icap_e);
		end else if (esum_raw < -icap_e) begin
			esum_next = ESUM_W'(-icap_e);
		end else begin
			esum_next = ESUM_W'(esum_raw);
		end
	end

	// state update as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			prev2_err_q <= '0;
			err_sum_q   <= '0;
			prev_tgt_q  <= '0;
		end else if (adv1) begin
			prev_err_q <= err;
			if (mode_incr) begin
				prev2_err_q <= prev_err_q;
			end else begin
				err_sum_q <= esum_next;
				if (mode_ff) begin
					prev_tgt_q <= tgt_s1;
				end
			end
		end
	end

	// operand register: pick what each gain multiplies
	always_ff @(posedge clk) begin
		if (adv1) begin
			incr_s2 <= mode_incr;
			op_p_s2 <= mode_incr ? OPND_W'(diff1) : OPND_W'(err);
			op_i_s2 <= mode_incr ? OPND_W'(err) : OPND_W'(esum_next);
			op_d_s2 <= mode_incr ? diff2 : OPND_W'(diff1);
			op_f_s2 <= mode_ff ? OPND_W'(tgt_diff) : '0;
		end
	end

	// four gain products
	pidc_qmul u_mul_p (.clk(clk), .en(rdy3 && v2_s2), .gain(gain_p_q), .opnd(op_p_s2),
		.prod_s3(p_s3));
	pidc_qmul u_mul_i (.clk(clk), .en(rdy3 && v2_s2), .gain(gain_i_q), .opnd(op_i_s2),
		.prod_s3(i_s3));
	pidc_qmul u_mul_d (.clk(clk), .en(rdy3 && v2_s2), .gain(gain_d_q), .opnd(op_d_s2),
		.prod_s3(d_s3));
	pidc_qmul u_mul_f (.clk(clk), .en(rdy3 && v2_s2), .gain(gain_f_q), .opnd(op_f_s2),
		.prod_s3(f_s3));

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			incr_s3 <= incr_s2;
		end
	end

	// incremental integral term clamp, then the sum of terms
	assign icap_p = $signed(PROD_W'(int_cap_q));

	always_comb begin
		if (incr_s3 && (i_s3 > icap_p)) begin
			i_term = icap_p;
		end else if (incr_s3 && (i_s3 < -icap_p)) begin
			i_term = -icap_p;
		end else begin
			i_term = i_s3;
		end
	end

	assign sum = SUM_W'(p_s3) + SUM_W'(i_term) + SUM_W'(d_s3) + SUM_W'(f_s3);

	always_ff @(posedge clk) begin
		if (rdy4 && v3_s3) begin
			sum_s4 <= sum;
		end
	end

	// output clamp
	assign ocap_s = $signed(SUM_W'(out_cap_q));

	always_comb begin
		if (sum_s4 > ocap_s) begin
			drive_next = DATA_W'(ocap_s);
			sat_next   = 1'b1;
		end else if (sum_s4 < -ocap_s) begin
			drive_next = DATA_W'(-ocap_s);
			sat_next   = 1'b1;
		end else begin
			drive_next = DATA_W'(sum_s4);
			sat_next   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v4_s4) begin
			drive_q <= drive_next;
			sat_q   <= sat_next;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.saturated = sat_q;

	// checks
	assign ocap_d = $signed(DATA_W'(out_cap_q));

	a_drive_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (drive_q <= ocap_d) && (drive_q >= -ocap_d))
		else $error("drive outside output cap");

	a_sat_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sat_q) |-> (drive_q == ocap_d) || (drive_q == -ocap_d))
		else $error("saturated flag without drive at cap");

	a_incr_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && mode_incr) |=> (prev2_err_q == $past(prev_err_q)) && $stable(err_sum_q))
		else $error("incremental state update wrong");

	a_tgt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && !mode_ff) |=> $stable(prev_tgt_q))
		else $error("last target changed outside feedforward mode");
endmodule

/* hdl/pidc_qmul.sv */
`timescale 1ns / 1ps

module pidc_qmul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [pidc_pkg::GAIN_W-1:0] gain,
	input  logic signed [pidc_pkg::OPND_W-1:0] opnd,
	output logic signed [pidc_pkg::PROD_W-1:0] prod_s3
);
	import pidc_pkg::*;

	localparam int FULL_W = GAIN_W + OPND_W;

	logic signed [FULL_W-1:0] full;

	// exact signed product
	assign full = gain * opnd;

	// drop the fraction bits: arithmetic shift, floor rounding
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= full[FULL_W-1:FRAC_W];
		end
	end
endmodule

/* sim/tb_pid_controller_three_mode_core.sv */
`timescale 1ns / 1ps

module tb_pid_controller_three_mode_core;
	import pidc_pkg::*;

	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic [GAIN_W-1:0] ONE      = 32'h0001_0000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic                     saturated;
	} drive_item_t;

	// tracks controller state and the drive values still owed by the block
	class drive_scoreboard;
		logic [MODE_W-1:0] mode;
		longint kp, ki, kd, kf, int_cap, out_cap;
		longint last_err, older_err, err_sum, last_target;
		drive_item_t pending_drives[$];
		int errors;

		function new();
			mode = MODE_POS;
			kp = 0; ki = 0; kd = 0; kf = 0;
			int_cap = 0; out_cap = 0;
			last_err = 0; older_err = 0; err_sum = 0; last_target = 0;
			errors = 0;
		endfunction

		// exact gain product, floored after dropping the fraction bits
		function longint scale_mul(longint g, longint d);
			logic signed [79:0] gw, dw, prod;
			gw = g;
			dw = d;
			prod = gw * dw;
			return longint'(prod >>> FRAC_W);
		endfunction

		function longint clamp_sym(longint x, longint cap);
			if (x > cap)
				return cap;
			if (x < -cap)
				return -cap;
			return x;
		endfunction

		function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MODE:    mode = data[MODE_W-1:0];
				CFG_GAIN_P:  kp = longint'($signed(data));
				CFG_GAIN_I:  ki = longint'($signed(data));
				CFG_GAIN_D:  kd = longint'($signed(data));
				CFG_GAIN_F:  kf = longint'($signed(data));
				CFG_INT_CAP: int_cap = longint'({33'd0, data[CAP_W-1:0]});
				CFG_OUT_CAP: out_cap = longint'({33'd0, data[CAP_W-1:0]});
				default: ;
			endcase
		endfunction

		// predict the drive for one accepted sample and advance the state
		function void note_sample(logic signed [DATA_W-1:0] m, logic signed [DATA_W-1:0] t);
			longint e, total, clamped;
			drive_item_t exp_item;
			e = longint'(t) - longint'(m);
			if (mode == MODE_INCR) begin
				total = scale_mul(kp, e - last_err)
					+ clamp_sym(scale_mul(ki, e), int_cap)
					+ scale_mul(kd, e - 2 * last_err + older_err);
				older_err = last_err;
			end else begin
				err_sum = clamp_sym(err_sum + e, int_cap);
				total = scale_mul(kp, e) + scale_mul(ki, err_sum) + scale_mul(kd, e - last_err);
				// feedforward, also taken by the spare mode code
				if (mode != MODE_POS) begin
					total += scale_mul(kf, longint'(t) - last_target);
					last_target = longint'(t);
				end
			end
			last_err = e;
			clamped = clamp_sym(total, out_cap);
			exp_item.drive = clamped[DATA_W-1:0];
			exp_item.saturated = (clamped != total);
			pending_drives.push_back(exp_item);
		endfunction

		function void check_drive(logic signed [DATA_W-1:0] drive, logic saturated);
			drive_item_t exp_item;
			if (pending_drives.size() == 0) begin
				$error("unexpected result item: drive %0d saturated %0b", drive, saturated);
				errors++;
				return;
			end
			exp_item = pending_drives.pop_front();
			if (drive !== exp_item.drive) begin
				$error("drive: expected %0d, got %0d", exp_item.drive, drive);
				errors++;
			end
			if (saturated !== exp_item.saturated) begin
				$error("saturated: expected %0b, got %0b", exp_item.saturated, saturated);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_drives.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pidc_sample_if sample_ch();
	pidc_result_if result_ch();

	drive_scoreboard drive_board = new();

	bit steady = 1'b0;
	bit hold_off_pending = 1'b0;
	logic signed [DATA_W-1:0] held_target = '0;
	int stall_cycles = 0;

	pid_controller_three_mode_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// check results before noting samples taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				drive_board.check_drive(result_ch.drive, result_ch.saturated);
			if (sample_ch.valid && sample_ch.ready)
				drive_board.note_sample(sample_ch.measured, sample_ch.target);
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random back-pressure, plus a long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= 18);
			end
		end
	end

	task automatic send_sample(input logic signed [DATA_W-1:0] m, input logic signed [DATA_W-1:0] t);
		// one idle cycle before some items
		if (!steady && $urandom_range(0, 99) < 22) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.measured <= m;
		sample_ch.target   <= t;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	// stop offering items and wait for every owed result
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (drive_board.outstanding() != 0)
			@(posedge clk);
	endtask

	// write every register, enable held high across the burst
	task automatic write_config(input logic [MODE_W-1:0] md, input logic [GAIN_W-1:0] kp,
			input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] kf,
			input logic [CAP_W-1:0] icap, input logic [CAP_W-1:0] ocap);
		logic [CFG_DATA_W-1:0] vals [7];
		logic [CFG_IDX_W-1:0] idxs [7];
		int k;
		vals = '{{30'd0, md}, kp, ki, kd, kf, {1'b0, icap}, {1'b0, ocap}};
		idxs = '{CFG_MODE, CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_GAIN_F,
			CFG_INT_CAP, CFG_OUT_CAP};
		drain_results();
		for (k = 0; k < 7; k++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data  <= vals[k];
			@(posedge clk);
			drive_board.apply_config(idxs[k], vals[k]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3, 4: return $urandom;
			default: return 32'(int'($urandom_range(0, 'h8_0000)) - 'h4_0000);
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] rand_cap();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2, 3: return 31'($urandom);
			default: return 31'($urandom_range(0, 'h40_0000));
		endcase
	endfunction

	// loop-like samples near the target, raw noise, extremes and a repeated target
	function automatic void pick_sample(output logic signed [DATA_W-1:0] m,
			output logic signed [DATA_W-1:0] t);
		logic signed [DATA_W-1:0] corners [5];
		int kind;
		corners = '{Q_MIN, Q_MAX, 32'sd0, -32'sd1, 32'sd1};
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			m = $urandom;
			t = $urandom;
		end else if (kind < 75) begin
			t = 32'(int'($urandom_range(0, 'h20_0000)) - 'h10_0000);
			m = t + 32'(int'($urandom_range(0, 'h4_0000)) - 'h2_0000);
		end else if (kind < 88) begin
			m = corners[$urandom_range(0, 4)];
			t = corners[$urandom_range(0, 4)];
		end else begin
			t = held_target;
			m = $urandom;
		end
		held_target = t;
	endfunction

	initial begin
		logic signed [DATA_W-1:0] m, t;
		int sent, n, phase, k;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.measured = '0;
		sample_ch.target = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: positional, zero gains, zero caps
		send_sample(32'sd0, 32'sd0);
		send_sample(Q_MIN, Q_MAX);

		// positional with a tight integral clamp, full-range errors
		write_config(MODE_POS, ONE, 32'h0000_8000, 32'h0002_0000, '0, 31'h0003_0000, 31'h7FFF_FFFF);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(32'sh0001_0000, 32'sh0003_0000);
		send_sample(32'sd0, 32'sd0);

		// incremental with a small output cap
		write_config(MODE_INCR, ONE, 32'h0000_8000, 32'h0002_0000, '0, 31'h0000_4000, 31'h0005_0000);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(32'sd0, 32'sh0001_0000);
		send_sample(32'sh0001_0000, 32'sd0);

		// feedforward on large target steps
		write_config(MODE_FF, ONE, 32'h0000_8000, 32'h0002_0000, 32'h0001_8000, 31'h0003_0000,
			31'h7FFF_FFFF);
		send_sample(32'sd0, Q_MAX);
		send_sample(32'sd0, Q_MIN);
		send_sample(32'sd5, 32'sd5);

		// spare mode code runs as feedforward
		write_config(MODE_SPARE, ONE, 32'h0000_8000, 32'h0002_0000, 32'h0001_8000, 31'h0003_0000,
			31'h7FFF_FFFF);
		send_sample(32'sd0, 32'sh0002_0000);
		send_sample(32'sh0000_1000, Q_MIN);

		// extreme gains and caps
		write_config(MODE_FF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);

		// zero output cap while the error sum grows large
		write_config(MODE_POS, '0, ONE, '0, '0, 31'h7FFF_FFFF, '0);
		send_sample(32'sd0, 32'sh4000_0000);
		send_sample(32'sd0, 32'sh4000_0000);

		// shrinking the integral cap only bites at the next update
		write_config(MODE_POS, '0, ONE, '0, '0, 31'h0001_0000, 31'h7FFF_FFFF);
		send_sample(32'sd0, 32'sd0);

		// incremental with a zero integral cap
		write_config(MODE_INCR, ONE, ONE, ONE, ONE, '0, 31'h7FFF_FFFF);
		send_sample(32'sd0, 32'sh0001_0000);

		// random phases, each with fresh settings
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				1: write_config(MODE_FF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					31'h7FFF_FFFF, 31'h7FFF_FFFF);
				2: write_config(MODE_INCR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, '0, '0);
				default: write_config(MODE_W'($urandom_range(0, 3)), rand_gain(), rand_gain(),
					rand_gain(), rand_gain(), rand_cap(), rand_cap());
			endcase
			steady = (phase == 3);
			if (phase == 4)
				hold_off_pending = 1'b1;
			n = (phase == 3) ? 150 : $urandom_range(20, 80);
			for (k = 0; k < n; k++) begin
				pick_sample(m, t);
				send_sample(m, t);
				// sender pause until all results are back
				if (phase == 5 && k == n / 2)
					drain_results();
			end
			sent += n;
			phase++;
		end
		steady = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		if (drive_board.errors == 0 && drive_board.outstanding() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
hdl/pidc_pkg.sv
hdl/pidc_sample_if.sv
hdl/pidc_result_if.sv
hdl/pidc_qmul.sv
hdl/pid_controller_three_mode_core.sv
sim/tb_pid_controller_three_mode_core.sv
